// ===== src/dgt_pkg.sv =====
// ----------------------------------------------------------------------------
// dgt_pkg
// Shared types, codes and helpers for the direction gate table.
// ----------------------------------------------------------------------------
package dgt_pkg;

  localparam int DefCapacity = 8;
  localparam int DefMagBits  = 8;
  localparam int CodeW       = 5;
  localparam int MagOutW     = 8;
  localparam int OffW        = 9;
  localparam int CountOutW   = 5;

  localparam logic [CodeW-1:0] NumCodes   = 5'd27;
  localparam logic [CodeW-1:0] CentreCode = 5'd13;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_SET   = 2'd1,
    OP_GET   = 2'd2,
    OP_LIST  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_BAD_CODE = 3'd2,
    ST_ZERO_MAG = 3'd3,
    ST_FULL     = 3'd4,
    ST_DONE     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN
  } state_t;

  // One result handed from the sequencer to the output stage.
  typedef struct packed {
    logic                 valid;
    status_t              status;
    logic                 found;
    logic [CodeW-1:0]     code;
    logic [MagOutW-1:0]   mag;
    logic                 is_list;
    logic                 last;
    logic [CountOutW-1:0] count;
  } res_t;

  // Axis digit (0..2) of a neighbor code; axis 0 is x, 1 is y, 2 is z.
  function automatic logic [1:0] axis_digit(input logic [CodeW-1:0] code,
                                            input logic [1:0] axis);
    logic [1:0]       z;
    logic [1:0]       y;
    logic [CodeW-1:0] rem;
    z = (code >= 5'd18) ? 2'd2 : ((code >= 5'd9) ? 2'd1 : 2'd0);
    rem = code - 5'(z) * 5'd9;
    y = (rem >= 5'd6) ? 2'd2 : ((rem >= 5'd3) ? 2'd1 : 2'd0);
    rem = rem - 5'(y) * 5'd3;
    unique case (axis)
      2'd0:    return rem[1:0];
      2'd1:    return y;
      default: return z;
    endcase
  endfunction

  // Digit 0 means -1, 1 means 0, 2 means +1, scaled by the magnitude.
  function automatic logic signed [OffW-1:0] scaled_offset(input logic [1:0] digit,
                                                           input logic [MagOutW-1:0] mag);
    logic signed [OffW-1:0] m;
    m = $signed({1'b0, mag});
    unique case (digit)
      2'd0:    return -m;
      2'd2:    return m;
      default: return '0;
    endcase
  endfunction

endpackage

// ===== src/dgt_ram.sv =====
// ----------------------------------------------------------------------------
// dgt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dgt_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/dgt_seq.sv =====
// ----------------------------------------------------------------------------
// dgt_seq
// Command sequencer: checks a command, scans the entry RAM one entry per
// cycle and writes updates or appends back.
// ----------------------------------------------------------------------------
module dgt_seq #(
  parameter int CAPACITY = dgt_pkg::DefCapacity,
  parameter int MAG_BITS = dgt_pkg::DefMagBits
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [1:0]                  opcode,
  input  logic [dgt_pkg::CodeW-1:0]   code_in,
  input  logic [dgt_pkg::MagOutW-1:0] mag_in,
  output logic                        busy,
  output dgt_pkg::res_t               res
);

  localparam int MW   = (MAG_BITS < dgt_pkg::MagOutW) ? MAG_BITS : dgt_pkg::MagOutW;
  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int EW   = dgt_pkg::CodeW + MW;

  dgt_pkg::state_t state_r, state_nxt;
  dgt_pkg::op_t    op_r;
  logic [dgt_pkg::CodeW-1:0] code_r;
  logic [MW-1:0]             mag_r;
  logic [CntW-1:0]           count_r, count_nxt;
  logic [CntW-1:0]           rd_idx_r, rd_idx_nxt;
  logic [CntW-1:0]           ridx_r;
  logic                      rvalid_r, rvalid_nxt;
  logic                      issue;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;

  logic [dgt_pkg::CodeW-1:0] ent_code;
  logic [MW-1:0]             ent_mag;
  logic                      hit;
  logic                      last_ent;
  logic                      reject;
  logic                      accept;

  assign accept   = start && (state_r == dgt_pkg::S_IDLE);
  assign busy     = (state_r != dgt_pkg::S_IDLE);
  assign ent_code = ram_rdata[EW-1:MW];
  assign ent_mag  = ram_rdata[MW-1:0];
  assign hit      = rvalid_r && (ent_code == code_r);
  assign last_ent = (ridx_r == count_r - CntW'(1));
  assign reject   = (code_r >= dgt_pkg::NumCodes) || (mag_r == '0) ||
                    (count_r >= CntW'(CAPACITY));

  dgt_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dgt_pkg::S_IDLE: begin
        if (start) state_nxt = dgt_pkg::S_CHECK;
      end
      dgt_pkg::S_CHECK: begin
        unique case (op_r)
          dgt_pkg::OP_CLEAR: state_nxt = dgt_pkg::S_IDLE;
          dgt_pkg::OP_SET: begin
            state_nxt = (reject || count_r == '0) ? dgt_pkg::S_IDLE : dgt_pkg::S_SCAN;
          end
          default: begin
            state_nxt = (count_r == '0) ? dgt_pkg::S_IDLE : dgt_pkg::S_SCAN;
          end
        endcase
      end
      dgt_pkg::S_SCAN: begin
        if (rvalid_r) begin
          if (op_r == dgt_pkg::OP_LIST) begin
            if (last_ent) state_nxt = dgt_pkg::S_IDLE;
          end else if (hit || last_ent) begin
            state_nxt = dgt_pkg::S_IDLE;
          end
        end
      end
      default: state_nxt = dgt_pkg::S_IDLE;
    endcase
  end

  // Datapath and results.
  always_comb begin
    res        = '0;
    ram_we     = 1'b0;
    ram_waddr  = count_r[AW-1:0];
    ram_wdata  = {code_r, mag_r};
    count_nxt  = count_r;
    rd_idx_nxt = rd_idx_r;
    issue      = 1'b0;
    unique case (state_r)
      dgt_pkg::S_CHECK: begin
        rd_idx_nxt = '0;
        res.status = dgt_pkg::ST_DONE;
        res.last   = 1'b1;
        unique case (op_r)
          dgt_pkg::OP_CLEAR: begin
            res.valid = 1'b1;
            count_nxt = '0;
          end
          dgt_pkg::OP_SET: begin
            priority if (code_r >= dgt_pkg::NumCodes) begin
              res.valid  = 1'b1;
              res.status = dgt_pkg::ST_BAD_CODE;
            end else if (mag_r == '0) begin
              res.valid  = 1'b1;
              res.status = dgt_pkg::ST_ZERO_MAG;
            end else if (count_r >= CntW'(CAPACITY)) begin
              res.valid  = 1'b1;
              res.status = dgt_pkg::ST_FULL;
            end else if (count_r == '0) begin
              // Empty table: append without a scan.
              res.valid  = 1'b1;
              res.status = dgt_pkg::ST_INSERTED;
              res.code   = code_r;
              res.mag    = dgt_pkg::MagOutW'(mag_r);
              ram_we     = 1'b1;
              count_nxt  = count_r + CntW'(1);
            end else begin
              res.valid = 1'b0;
            end
          end
          default: begin
            res.valid = (count_r == '0);
          end
        endcase
      end
      dgt_pkg::S_SCAN: begin
        issue = (rd_idx_r < count_r);
        if (issue) rd_idx_nxt = rd_idx_r + CntW'(1);
        if (rvalid_r) begin
          res.status = dgt_pkg::ST_DONE;
          res.last   = 1'b1;
          unique case (op_r)
            dgt_pkg::OP_LIST: begin
              res.valid   = 1'b1;
              res.found   = 1'b1;
              res.is_list = 1'b1;
              res.code    = ent_code;
              res.mag     = dgt_pkg::MagOutW'(ent_mag);
              res.last    = last_ent;
            end
            dgt_pkg::OP_GET: begin
              res.valid = hit || last_ent;
              if (hit) begin
                res.found = 1'b1;
                res.code  = ent_code;
                res.mag   = dgt_pkg::MagOutW'(ent_mag);
              end
            end
            dgt_pkg::OP_SET: begin
              res.valid = hit || last_ent;
              res.code  = code_r;
              res.mag   = dgt_pkg::MagOutW'(mag_r);
              if (hit) begin
                res.status = dgt_pkg::ST_UPDATED;
                ram_we     = 1'b1;
                ram_waddr  = ridx_r[AW-1:0];
              end else if (last_ent) begin
                res.status = dgt_pkg::ST_INSERTED;
                ram_we     = 1'b1;
                count_nxt  = count_r + CntW'(1);
              end
            end
            default: res.valid = 1'b0;
          endcase
        end
      end
      default: begin
        rd_idx_nxt = rd_idx_r;
      end
    endcase
    res.count = dgt_pkg::CountOutW'(count_nxt);
  end

  // A read still in flight when the scan ends is dropped.
  assign rvalid_nxt = issue && (state_nxt == dgt_pkg::S_SCAN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= dgt_pkg::S_IDLE;
      count_r  <= '0;
      rvalid_r <= 1'b0;
      rd_idx_r <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      rvalid_r <= rvalid_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ridx_r <= rd_idx_r;
    if (accept) begin
      op_r   <= dgt_pkg::op_t'(opcode);
      code_r <= code_in;
      mag_r  <= mag_in[MW-1:0];
    end
  end

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_rvalid_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rvalid_r |-> state_r == dgt_pkg::S_SCAN)
    else $error("read data returned outside a scan");

  a_write_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> res.valid && (res.status == dgt_pkg::ST_INSERTED ||
                             res.status == dgt_pkg::ST_UPDATED))
    else $error("RAM write without an insert or update result");

  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == dgt_pkg::S_CHECK)
    else $error("accepted command did not reach the check state");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.last |=> state_r != dgt_pkg::S_SCAN)
    else $error("scan continued after the final result");

endmodule

// ===== src/direction_gate_table.sv =====
// ----------------------------------------------------------------------------
// direction_gate_table
// Keyed table of direction codes (3x3x3 neighbor offsets) and magnitudes.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken when start is high and busy is low. in_opcode selects
//   clear, set, get or list; in_direction_code and in_magnitude_in carry the
//   key and value. Results appear on the out_ ports for one cycle with
//   out_valid high, and out_last marks the final result of a command.
//   The receiver cannot stall, so each result transfer completes in the
//   cycle it is shown.
//   Clear, a rejected set and any command on an empty table are answered
//   from the check state. Set and get scan the entry RAM one entry per
//   cycle until a hit or the last stored entry; list gives one result per
//   stored entry, one per cycle, with out_last on the final one.
//   The next command can be taken the cycle after the final result leaves
//   the sequencer, while that result still sits in the output register.
//   Throughput is set by the single read port of the entry RAM.
//   Reset empties the table; the entry RAM is not cleared, since only
//   entries below the count are ever read.
// ----------------------------------------------------------------------------
module direction_gate_table #(
  parameter int CAPACITY = dgt_pkg::DefCapacity,
  parameter int MAG_BITS = dgt_pkg::DefMagBits
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_opcode,
  input  logic [dgt_pkg::CodeW-1:0]          in_direction_code,
  input  logic [dgt_pkg::MagOutW-1:0]        in_magnitude_in,
  output logic                               out_valid,
  output logic [2:0]                         out_status,
  output logic                               out_found,
  output logic [dgt_pkg::CodeW-1:0]          out_code_out,
  output logic [dgt_pkg::MagOutW-1:0]        out_magnitude_out,
  output logic signed [dgt_pkg::OffW-1:0]   out_offset_x,
  output logic signed [dgt_pkg::OffW-1:0]   out_offset_y,
  output logic signed [dgt_pkg::OffW-1:0]   out_offset_z,
  output logic                               out_is_centre,
  output logic [dgt_pkg::CountOutW-1:0]      out_entry_count,
  output logic                               out_last
);

  dgt_pkg::res_t res;

  logic                             out_valid_r;
  logic signed [dgt_pkg::OffW-1:0] off_x_nxt, off_y_nxt, off_z_nxt;
  logic                             centre_nxt;

  dgt_seq #(
    .CAPACITY(CAPACITY),
    .MAG_BITS(MAG_BITS)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .opcode  (in_opcode),
    .code_in (in_direction_code),
    .mag_in  (in_magnitude_in),
    .busy    (busy),
    .res     (res)
  );

  // Offsets and the center flag only exist for listed entries.
  always_comb begin
    off_x_nxt  = '0;
    off_y_nxt  = '0;
    off_z_nxt  = '0;
    centre_nxt = 1'b0;
    if (res.is_list) begin
      off_x_nxt  = dgt_pkg::scaled_offset(dgt_pkg::axis_digit(res.code, 2'd0), res.mag);
      off_y_nxt  = dgt_pkg::scaled_offset(dgt_pkg::axis_digit(res.code, 2'd1), res.mag);
      off_z_nxt  = dgt_pkg::scaled_offset(dgt_pkg::axis_digit(res.code, 2'd2), res.mag);
      centre_nxt = (res.code == dgt_pkg::CentreCode);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_status        <= res.status;
      out_found         <= res.found;
      out_code_out      <= res.code;
      out_magnitude_out <= res.mag;
      out_offset_x      <= off_x_nxt;
      out_offset_y      <= off_y_nxt;
      out_offset_z      <= off_z_nxt;
      out_is_centre     <= centre_nxt;
      out_entry_count   <= res.count;
      out_last          <= res.last;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sim/direction_gate_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direction_gate_table_test
// Self-checking bench for the direction gate table. A short table of
// directed commands covers the empty table, rejection codes, updates, a full
// table and listing. Random commands with bursty gaps on the command side
// follow. Every result transfer is compared with a local prediction of the
// table contents.
// ----------------------------------------------------------------------------
module direction_gate_table_test;

  localparam int TableDepth     = dgt_pkg::DefCapacity;
  localparam int MagMask        = (1 << dgt_pkg::DefMagBits) - 1;
  localparam int RandomCommands = 285;
  localparam int CalmTail       = 40;
  localparam int MaxReported    = 10;

  typedef struct packed {
    logic [2:0]                         status;
    logic                               found;
    logic [dgt_pkg::CodeW-1:0]          code;
    logic [dgt_pkg::MagOutW-1:0]        mag;
    logic signed [dgt_pkg::OffW-1:0]    off_x;
    logic signed [dgt_pkg::OffW-1:0]    off_y;
    logic signed [dgt_pkg::OffW-1:0]    off_z;
    logic                               centre;
    logic [dgt_pkg::CountOutW-1:0]      count;
    logic                               last;
  } table_result_t;

  typedef struct {
    dgt_pkg::op_t                op;
    logic [dgt_pkg::CodeW-1:0]   code;
    logic [dgt_pkg::MagOutW-1:0] mag;
    bit                          has_fixed;
    table_result_t               fixed;
  } command_row_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic [1:0]                        in_opcode = '0;
  logic [dgt_pkg::CodeW-1:0]         in_direction_code = '0;
  logic [dgt_pkg::MagOutW-1:0]       in_magnitude_in = '0;
  logic                              out_valid;
  logic [2:0]                        out_status;
  logic                              out_found;
  logic [dgt_pkg::CodeW-1:0]         out_code_out;
  logic [dgt_pkg::MagOutW-1:0]       out_magnitude_out;
  logic signed [dgt_pkg::OffW-1:0]   out_offset_x;
  logic signed [dgt_pkg::OffW-1:0]   out_offset_y;
  logic signed [dgt_pkg::OffW-1:0]   out_offset_z;
  logic                              out_is_centre;
  logic [dgt_pkg::CountOutW-1:0]     out_entry_count;
  logic                              out_last;

  // Local copy of the table contents.
  logic [dgt_pkg::CodeW-1:0]   model_code [TableDepth];
  logic [dgt_pkg::MagOutW-1:0] model_mag  [TableDepth];
  int                          model_count = 0;

  table_result_t expected_results [$];
  command_row_t  directed_rows [$];

  int fail_count    = 0;
  int results_seen  = 0;
  int full_rejects  = 0;
  int op_count [4]  = '{0, 0, 0, 0};

  direction_gate_table uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_direction_code (in_direction_code),
    .in_magnitude_in   (in_magnitude_in),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_found         (out_found),
    .out_code_out      (out_code_out),
    .out_magnitude_out (out_magnitude_out),
    .out_offset_x      (out_offset_x),
    .out_offset_y      (out_offset_y),
    .out_offset_z      (out_offset_z),
    .out_is_centre     (out_is_centre),
    .out_entry_count   (out_entry_count),
    .out_last          (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("direction_gate_table regression: fail");
    $finish;
  end

  function automatic table_result_t plain_result(logic [2:0] status, logic found,
                                                 logic [dgt_pkg::CodeW-1:0] code,
                                                 logic [dgt_pkg::MagOutW-1:0] mag,
                                                 int count);
    table_result_t r;
    r        = '0;
    r.status = status;
    r.found  = found;
    r.code   = code;
    r.mag    = mag;
    r.count  = dgt_pkg::CountOutW'(count);
    r.last   = 1'b1;
    return r;
  endfunction

  function automatic string show(table_result_t r);
    return {$sformatf("status=%0d found=%0d code=%0d mag=%0d ",
                      r.status, r.found, r.code, r.mag),
            $sformatf("off=(%0d,%0d,%0d) centre=%0d count=%0d last=%0d",
                      r.off_x, r.off_y, r.off_z, r.centre, r.count, r.last)};
  endfunction

  function automatic void note_failure(string what);
    fail_count++;
    if (fail_count <= MaxReported) begin
      $display("[%0t] ERROR: %s", $time, what);
    end
  endfunction

  function automatic int find_entry(logic [dgt_pkg::CodeW-1:0] code);
    for (int i = 0; i < model_count; i++) begin
      if (model_code[i] == code) return i;
    end
    return -1;
  endfunction

  // Applies one command to the local table and, when keep is set, queues
  // the results it is predicted to produce.
  task automatic predict_command(input dgt_pkg::op_t op,
                                 input logic [dgt_pkg::CodeW-1:0] code,
                                 input logic [dgt_pkg::MagOutW-1:0] mag_raw,
                                 input bit keep);
    table_result_t               batch [$];
    table_result_t               r;
    logic [dgt_pkg::MagOutW-1:0] mag;
    int                          slot;
    int                          c;
    int                          m;
    mag = mag_raw & dgt_pkg::MagOutW'(MagMask);
    unique case (op)
      dgt_pkg::OP_CLEAR: begin
        model_count = 0;
        batch = {batch, plain_result(dgt_pkg::ST_DONE, 1'b0, '0, '0, 0)};
      end
      dgt_pkg::OP_SET: begin
        // The full check comes before the search, so a full table also
        // turns away an update of a stored code.
        if (code >= dgt_pkg::NumCodes) begin
          batch = {batch, plain_result(dgt_pkg::ST_BAD_CODE, 1'b0, '0, '0, model_count)};
        end else if (mag == '0) begin
          batch = {batch, plain_result(dgt_pkg::ST_ZERO_MAG, 1'b0, '0, '0, model_count)};
        end else if (model_count >= TableDepth) begin
          batch = {batch, plain_result(dgt_pkg::ST_FULL, 1'b0, '0, '0, model_count)};
        end else begin
          slot = find_entry(code);
          if (slot >= 0) begin
            model_mag[slot] = mag;
            batch = {batch, plain_result(dgt_pkg::ST_UPDATED, 1'b0, code, mag,
                                         model_count)};
          end else begin
            model_code[model_count] = code;
            model_mag[model_count]  = mag;
            model_count++;
            batch = {batch, plain_result(dgt_pkg::ST_INSERTED, 1'b0, code, mag,
                                         model_count)};
          end
        end
      end
      dgt_pkg::OP_GET: begin
        slot = find_entry(code);
        if (slot >= 0) begin
          batch = {batch, plain_result(dgt_pkg::ST_DONE, 1'b1, model_code[slot],
                                       model_mag[slot], model_count)};
        end else begin
          batch = {batch, plain_result(dgt_pkg::ST_DONE, 1'b0, '0, '0, model_count)};
        end
      end
      default: begin
        if (model_count == 0) begin
          batch = {batch, plain_result(dgt_pkg::ST_DONE, 1'b0, '0, '0, 0)};
        end
        for (int i = 0; i < model_count; i++) begin
          c = int'(model_code[i]);
          m = int'(model_mag[i]);
          r = plain_result(dgt_pkg::ST_DONE, 1'b1, model_code[i], model_mag[i],
                           model_count);
          r.off_x  = dgt_pkg::OffW'((c % 3 - 1) * m);
          r.off_y  = dgt_pkg::OffW'(((c % 9) / 3 - 1) * m);
          r.off_z  = dgt_pkg::OffW'((c / 9 - 1) * m);
          r.centre = (model_code[i] == dgt_pkg::CentreCode);
          r.last   = (i == model_count - 1);
          batch = {batch, r};
        end
      end
    endcase
    if (keep) begin
      expected_results = {expected_results, batch};
    end
  endtask

  // Presents one command and returns at the edge where it is transferred.
  task automatic issue_command(input dgt_pkg::op_t op,
                               input logic [dgt_pkg::CodeW-1:0] code,
                               input logic [dgt_pkg::MagOutW-1:0] mag, input int gap,
                               input bit from_model);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start             <= 1'b1;
    in_opcode         <= op;
    in_direction_code <= code;
    in_magnitude_in   <= mag;
    do @(posedge clk); while (busy);
    op_count[op]++;
    predict_command(op, code, mag, from_model);
  endtask

  function automatic int next_gap(bit bursty);
    if (!bursty || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 17);
  endfunction

  function automatic logic [dgt_pkg::CodeW-1:0] pick_known_code();
    if (model_count == 0) return dgt_pkg::CodeW'($urandom_range(0, 26));
    return model_code[$urandom_range(0, model_count - 1)];
  endfunction

  function automatic void add_row(dgt_pkg::op_t op, logic [dgt_pkg::CodeW-1:0] code,
                                  logic [dgt_pkg::MagOutW-1:0] mag);
    command_row_t r;
    r.op        = op;
    r.code      = code;
    r.mag       = mag;
    r.has_fixed = 1'b0;
    r.fixed     = '0;
    directed_rows = {directed_rows, r};
  endfunction

  function automatic void add_fixed_row(dgt_pkg::op_t op, logic [dgt_pkg::CodeW-1:0] code,
                                        logic [dgt_pkg::MagOutW-1:0] mag,
                                        dgt_pkg::status_t status, logic found,
                                        logic [dgt_pkg::CodeW-1:0] code_out,
                                        logic [dgt_pkg::MagOutW-1:0] mag_out, int count);
    command_row_t r;
    r.op        = op;
    r.code      = code;
    r.mag       = mag;
    r.has_fixed = 1'b1;
    r.fixed     = plain_result(status, found, code_out, mag_out, count);
    directed_rows = {directed_rows, r};
  endfunction

  always @(posedge clk) begin
    table_result_t want;
    table_result_t got;
    if (rst_n && out_valid === 1'b1) begin
      results_seen++;
      got.status = out_status;
      got.found  = out_found;
      got.code   = out_code_out;
      got.mag    = out_magnitude_out;
      got.off_x  = out_offset_x;
      got.off_y  = out_offset_y;
      got.off_z  = out_offset_z;
      got.centre = out_is_centre;
      got.count  = out_entry_count;
      got.last   = out_last;
      if (out_status == dgt_pkg::ST_FULL) full_rejects++;
      if (expected_results.size() == 0) begin
        note_failure($sformatf("result transfer with nothing pending: %s", show(got)));
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          note_failure($sformatf("mismatch\n  expected %s\n  actual   %s",
                                 show(want), show(got)));
        end
      end
    end
  end

  initial begin
    dgt_pkg::op_t                op;
    logic [dgt_pkg::CodeW-1:0]   code;
    logic [dgt_pkg::MagOutW-1:0] mag;
    bit                          bursty;
    int                          pick;
    int                          gap;

    bursty = 1'b1;

    // Empty table, rejections in priority order, then inserts and an update.
    add_fixed_row(dgt_pkg::OP_LIST, 5'd0,  8'd0,   dgt_pkg::ST_DONE,
                  1'b0, 5'd0,  8'd0,   0);
    add_fixed_row(dgt_pkg::OP_GET,  5'd5,  8'd0,   dgt_pkg::ST_DONE,
                  1'b0, 5'd0,  8'd0,   0);
    add_fixed_row(dgt_pkg::OP_SET,  5'd27, 8'd7,   dgt_pkg::ST_BAD_CODE,
                  1'b0, 5'd0,  8'd0,   0);
    add_fixed_row(dgt_pkg::OP_SET,  5'd31, 8'd0,   dgt_pkg::ST_BAD_CODE,
                  1'b0, 5'd0,  8'd0,   0);
    add_fixed_row(dgt_pkg::OP_SET,  5'd4,  8'd0,   dgt_pkg::ST_ZERO_MAG,
                  1'b0, 5'd0,  8'd0,   0);
    add_fixed_row(dgt_pkg::OP_SET,  5'd0,  8'd255, dgt_pkg::ST_INSERTED,
                  1'b0, 5'd0,  8'd255, 1);
    add_fixed_row(dgt_pkg::OP_SET,  5'd26, 8'd1,   dgt_pkg::ST_INSERTED,
                  1'b0, 5'd26, 8'd1,   2);
    add_fixed_row(dgt_pkg::OP_SET,  5'd13, 8'd128, dgt_pkg::ST_INSERTED,
                  1'b0, 5'd13, 8'd128, 3);
    add_fixed_row(dgt_pkg::OP_SET,  5'd0,  8'd1,   dgt_pkg::ST_UPDATED,
                  1'b0, 5'd0,  8'd1,   3);
    add_fixed_row(dgt_pkg::OP_GET,  5'd0,  8'd0,   dgt_pkg::ST_DONE,
                  1'b1, 5'd0,  8'd1,   3);
    add_fixed_row(dgt_pkg::OP_GET,  5'd31, 8'd0,   dgt_pkg::ST_DONE,
                  1'b0, 5'd0,  8'd0,   3);
    add_row(dgt_pkg::OP_LIST, 5'd0, 8'd0);
    // Fill the table to capacity.
    add_row(dgt_pkg::OP_SET, 5'd8,  8'd170);
    add_row(dgt_pkg::OP_SET, 5'd18, 8'd85);
    add_row(dgt_pkg::OP_SET, 5'd2,  8'd255);
    add_row(dgt_pkg::OP_SET, 5'd24, 8'd3);
    add_row(dgt_pkg::OP_SET, 5'd6,  8'd254);
    // A full table turns away new codes and updates alike, while the code
    // and magnitude checks still take precedence.
    add_fixed_row(dgt_pkg::OP_SET,  5'd9,  8'd9,   dgt_pkg::ST_FULL,
                  1'b0, 5'd0,  8'd0,   8);
    add_fixed_row(dgt_pkg::OP_SET,  5'd0,  8'd5,   dgt_pkg::ST_FULL,
                  1'b0, 5'd0,  8'd0,   8);
    add_fixed_row(dgt_pkg::OP_SET,  5'd27, 8'd0,   dgt_pkg::ST_BAD_CODE,
                  1'b0, 5'd0,  8'd0,   8);
    add_fixed_row(dgt_pkg::OP_SET,  5'd5,  8'd0,   dgt_pkg::ST_ZERO_MAG,
                  1'b0, 5'd0,  8'd0,   8);
    add_row(dgt_pkg::OP_LIST, 5'd31, 8'd255);
    add_row(dgt_pkg::OP_GET,  5'd24, 8'd0);
    add_fixed_row(dgt_pkg::OP_CLEAR, 5'd31, 8'd255, dgt_pkg::ST_DONE,
                  1'b0, 5'd0,  8'd0,   0);
    add_fixed_row(dgt_pkg::OP_LIST,  5'd0,  8'd0,   dgt_pkg::ST_DONE,
                  1'b0, 5'd0,  8'd0,   0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      issue_command(directed_rows[i].op, directed_rows[i].code, directed_rows[i].mag,
                    next_gap(1'b1), !directed_rows[i].has_fixed);
      if (directed_rows[i].has_fixed) begin
        expected_results = {expected_results, directed_rows[i].fixed};
      end
    end

    // Mostly sets and gets, 45 percent of them on codes already stored, so updates,
    // hits and a full table come up often; clears are rare enough to let it fill.
    for (int n = 0; n < RandomCommands; n++) begin
      if (n % 30 == 0) bursty = ($urandom_range(0, 2) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 7) op = dgt_pkg::OP_CLEAR;
      else if (pick < 52) op = dgt_pkg::OP_SET;
      else if (pick < 80) op = dgt_pkg::OP_GET;
      else op = dgt_pkg::OP_LIST;
      pick = $urandom_range(0, 99);
      if (pick < 45) code = pick_known_code();
      else if (pick < 85) code = dgt_pkg::CodeW'($urandom_range(0, 26));
      else code = dgt_pkg::CodeW'($urandom_range(0, 31));
      mag = ($urandom_range(0, 9) == 0) ? '0 : dgt_pkg::MagOutW'($urandom_range(0, 255));
      gap = (n < RandomCommands - CalmTail) ? next_gap(bursty) : 0;
      issue_command(op, code, mag, gap, 1'b1);
    end
    start <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (expected_results.size() != 0) begin
      note_failure($sformatf("%0d expected results never arrived", expected_results.size()));
    end

    $display("Covered %0d commands: %0d clear, %0d set, %0d get, %0d list.",
             op_count[0] + op_count[1] + op_count[2] + op_count[3],
             op_count[dgt_pkg::OP_CLEAR], op_count[dgt_pkg::OP_SET],
             op_count[dgt_pkg::OP_GET], op_count[dgt_pkg::OP_LIST]);
    $display("Checked %0d result transfers, %0d of them full-table rejections; %0d failures.",
             results_seen, full_rejects, fail_count);
    if (fail_count == 0) begin
      $display("direction_gate_table regression: pass");
    end else begin
      $display("direction_gate_table regression: fail");
    end
    $finish;
  end

endmodule

// ===== direction_gate_table.f =====
src/dgt_pkg.sv
src/dgt_ram.sv
src/dgt_seq.sv
src/direction_gate_table.sv
sim/direction_gate_table_test.sv
